// ===== rtl/tspg_pkg.sv =====
`default_nettype none

package tspg_pkg;

  // Default build widths.
  localparam int StepCountBitsDef = 16;
  localparam int DelayBitsDef     = 16;

  // Widths of the fixed stream and register fields.
  localparam int KindW      = 2;
  localparam int MoveStepsW = 16;
  localparam int PositionW  = 17;
  localparam int RevW       = 16;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int InDataW    = 24;
  localparam int OutDataW   = 40;

  // Request kinds.
  localparam logic [KindW-1:0] KindTick  = 2'd0;
  localparam logic [KindW-1:0] KindStart = 2'd1;
  localparam logic [KindW-1:0] KindZero  = 2'd2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegBaseDelay  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSlopeSteps = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSlopeCount = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDelayDec   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDirSense   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRevSteps   = 3'd5;

  // Register reset values.
  localparam logic [15:0] BaseDelayRst  = 16'd200;
  localparam logic [7:0]  SlopeStepsRst = 8'd45;
  localparam logic [5:0]  SlopeCountRst = 6'd21;
  localparam logic [7:0]  DelayDecRst   = 8'd8;
  localparam logic        DirSenseRst   = 1'b1;
  localparam logic [15:0] RevStepsRst   = 16'd1600;

  typedef struct packed {
    logic [15:0] base_delay;
    logic [7:0]  slope_steps;
    logic [5:0]  slope_count;
    logic [7:0]  delay_decrement;
    logic        direction_sense;
    logic [15:0] revolution_steps;
  } cfg_t;

  // Position update request from the profile sequencer.
  typedef struct packed {
    logic step;
    logic fwd;
    logic zero;
  } pos_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/trapezoid_step_pulse_generator_unit.sv =====
`default_nettype none

// Step pulse generator with a trapezoidal speed profile for an eighth-step
// driver. Each request on the input stream is a one-microsecond tick, a move
// start or a position clear (tuser), and each request yields exactly one
// result with the step line level, direction, busy and done flags and the
// signed position and revolution count after that request. The block takes
// one request per clock while the output is not stalled: a request is
// captured in the input register, is evaluated against the motion state and
// lands in the result register, from which its result is presented. The
// user must write registers through the plain write port only while no
// request is in flight; the block itself does not enforce this.

module trapezoid_step_pulse_generator_unit #(
  parameter int StepCountBits = tspg_pkg::StepCountBitsDef,
  parameter int DelayBits     = tspg_pkg::DelayBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tspg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [tspg_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] move_steps, [16] move_direction, [23:17] zero
  input  wire logic [tspg_pkg::InDataW-1:0]     s_axis_tdata,
  // [1:0] kind
  input  wire logic [tspg_pkg::KindW-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] step_pulse, [1] dir_level, [2] busy_res, [3] move_done,
  // [20:4] position, [36:21] revolutions, [39:37] zero
  output logic [tspg_pkg::OutDataW-1:0]         m_axis_tdata
);

  tspg_pkg::cfg_t      cfg;
  tspg_pkg::pos_ctrl_t pos_ctrl;

  logic                            in_valid_q;
  logic [tspg_pkg::KindW-1:0]      kind_q;
  logic [tspg_pkg::MoveStepsW-1:0] steps_q;
  logic                            dir_q;
  logic                            advance;
  logic                            out_valid_q;
  logic [tspg_pkg::OutDataW-1:0]   out_data_q;

  logic                                  step_pulse;
  logic                                  move_done;
  logic                                  busy;
  logic                                  dir_level;
  logic signed [tspg_pkg::PositionW-1:0] position;
  logic signed [tspg_pkg::RevW-1:0]      revolutions;

  // A request moves on when the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q  <= s_axis_tuser;
      steps_q <= s_axis_tdata[15:0];
      dir_q   <= s_axis_tdata[16];
    end
    if (advance) begin
      out_data_q <= {3'b000, revolutions, position, move_done, busy, dir_level, step_pulse};
    end
  end

  tspg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tspg_profile #(
    .StepCountBits (StepCountBits),
    .DelayBits     (DelayBits)
  ) u_profile (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .kind_i       (kind_q),
    .move_steps_i (steps_q),
    .move_dir_i   (dir_q),
    .cfg_i        (cfg),
    .step_pulse_o (step_pulse),
    .move_done_o  (move_done),
    .busy_o       (busy),
    .dir_level_o  (dir_level),
    .pos_ctrl_o   (pos_ctrl)
  );

  tspg_position u_position (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .ctrl_i        (pos_ctrl),
    .rev_steps_i   (cfg.revolution_steps),
    .position_o    (position),
    .revolutions_o (revolutions)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/tspg_cfg_regs.sv =====
`default_nettype none

module tspg_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tspg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tspg_pkg::CfgDataW-1:0] cfg_data_i,
  output tspg_pkg::cfg_t                    cfg_o
);

  tspg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tspg_pkg::RegBaseDelay:  cfg_d.base_delay       = cfg_data_i;
        tspg_pkg::RegSlopeSteps: cfg_d.slope_steps      = cfg_data_i[7:0];
        tspg_pkg::RegSlopeCount: cfg_d.slope_count      = cfg_data_i[5:0];
        tspg_pkg::RegDelayDec:   cfg_d.delay_decrement  = cfg_data_i[7:0];
        tspg_pkg::RegDirSense:   cfg_d.direction_sense  = cfg_data_i[0];
        tspg_pkg::RegRevSteps:   cfg_d.revolution_steps = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_delay       <= tspg_pkg::BaseDelayRst;
      cfg_q.slope_steps      <= tspg_pkg::SlopeStepsRst;
      cfg_q.slope_count      <= tspg_pkg::SlopeCountRst;
      cfg_q.delay_decrement  <= tspg_pkg::DelayDecRst;
      cfg_q.direction_sense  <= tspg_pkg::DirSenseRst;
      cfg_q.revolution_steps <= tspg_pkg::RevStepsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tspg_position.sv =====
`default_nettype none

module tspg_position (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire tspg_pkg::pos_ctrl_t                ctrl_i,
  input  wire logic [15:0]                        rev_steps_i,
  output logic signed [tspg_pkg::PositionW-1:0]   position_o,
  output logic signed [tspg_pkg::RevW-1:0]        revolutions_o
);

  // One spare bit so that a step past the largest wrap length cannot overflow.
  logic signed [17:0] pos_q, pos_d;
  logic signed [15:0] rev_q, rev_d;
  logic signed [17:0] rev_len;
  logic signed [17:0] pos_step;
  logic               wrap_up;
  logic               wrap_down;

  always_comb begin
    rev_len  = signed'({2'b00, (rev_steps_i == 16'd0) ? 16'd1 : rev_steps_i});
    pos_step = ctrl_i.fwd ? (pos_q + 18'sd1) : (pos_q - 18'sd1);

    if (rev_q == 16'sd0) begin
      wrap_up   = pos_step > rev_len;
      wrap_down = pos_step < -rev_len;
    end else if (rev_q > 16'sd0) begin
      wrap_up   = pos_step > rev_len;
      wrap_down = pos_step < 18'sd1;
    end else begin
      wrap_down = pos_step < -rev_len;
      wrap_up   = pos_step > -18'sd1;
    end

    pos_d = pos_q;
    rev_d = rev_q;
    if (en_i) begin
      if (ctrl_i.zero) begin
        pos_d = '0;
        rev_d = '0;
      end else if (ctrl_i.step) begin
        if (wrap_up) begin
          pos_d = pos_step - rev_len;
          if (rev_q != 16'sh7FFF) rev_d = rev_q + 16'sd1;
        end else if (wrap_down) begin
          pos_d = pos_step + rev_len;
          if (rev_q != -16'sh8000) rev_d = rev_q - 16'sd1;
        end else begin
          pos_d = pos_step;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rev_q <= '0;
    end else begin
      pos_q <= pos_d;
      rev_q <= rev_d;
    end
  end

  // The result register samples the updated values.
  assign position_o    = pos_d[tspg_pkg::PositionW-1:0];
  assign revolutions_o = rev_d;

endmodule

`default_nettype wire

// ===== rtl/tspg_profile.sv =====
`default_nettype none

module tspg_profile #(
  parameter int StepCountBits = tspg_pkg::StepCountBitsDef,
  parameter int DelayBits     = tspg_pkg::DelayBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic [tspg_pkg::KindW-1:0]      kind_i,
  input  wire logic [tspg_pkg::MoveStepsW-1:0] move_steps_i,
  input  wire logic                           move_dir_i,
  input  wire tspg_pkg::cfg_t                 cfg_i,
  output logic                                step_pulse_o,
  output logic                                move_done_o,
  output logic                                busy_o,
  output logic                                dir_level_o,
  output tspg_pkg::pos_ctrl_t                 pos_ctrl_o
);

  localparam int RampW = 14;
  localparam int CmpW  = (StepCountBits > RampW) ? StepCountBits : RampW;
  localparam int LvlW  = (DelayBits > RampW) ? DelayBits : RampW;

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhFlat   = 3'd1;
  localparam logic [2:0] PhAccel  = 3'd2;
  localparam logic [2:0] PhCruise = 3'd3;
  localparam logic [2:0] PhDecel  = 3'd4;

  logic [2:0]               phase_q, phase_d;
  logic [StepCountBits-1:0] steps_left_q, steps_left_d, steps_dec;
  logic [DelayBits-1:0]     delay_q, delay_d;
  logic [5:0]               level_q, level_d, level_sel;
  logic [7:0]               sil_q, sil_d, sil_inc;
  logic [DelayBits:0]       tick_q, tick_d, tick_lim;
  logic                     cdir_q, cdir_d;
  logic                     rdir_q, rdir_d;
  logic                     load_delay;
  logic [RampW-1:0]         ramp;
  logic [RampW-1:0]         lvl_prod;
  logic [LvlW-1:0]          lvl_base;
  logic [DelayBits-1:0]     lvl_delay;

  // Delay of one speed level: base minus level times decrement, floored at 0.
  always_comb begin
    lvl_prod  = level_sel * cfg_i.delay_decrement;
    lvl_base  = LvlW'(DelayBits'(cfg_i.base_delay));
    lvl_delay = (LvlW'(lvl_prod) >= lvl_base) ? '0 : DelayBits'(lvl_base - LvlW'(lvl_prod));
  end

  assign ramp     = cfg_i.slope_count * cfg_i.slope_steps;
  assign tick_lim = {1'b0, delay_q} + {{DelayBits{1'b0}}, 1'b1};
  assign steps_dec = steps_left_q - {{(StepCountBits-1){1'b0}}, 1'b1};
  assign sil_inc  = sil_q + 8'd1;

  always_comb begin
    phase_d      = phase_q;
    steps_left_d = steps_left_q;
    delay_d      = delay_q;
    level_d      = level_q;
    sil_d        = sil_q;
    tick_d       = tick_q;
    cdir_d       = cdir_q;
    rdir_d       = rdir_q;
    load_delay   = 1'b0;
    level_sel    = '0;
    step_pulse_o = 1'b0;
    move_done_o  = 1'b0;
    pos_ctrl_o   = '0;

    if (en_i) begin
      case (kind_i)
        tspg_pkg::KindTick: begin
          if (phase_q != PhIdle) begin
            if (tick_q == '0) begin
              step_pulse_o    = 1'b1;
              pos_ctrl_o.step = 1'b1;
              pos_ctrl_o.fwd  = cdir_q;
            end
            if (tick_q >= tick_lim) begin
              tick_d       = '0;
              steps_left_d = steps_dec;
              if (steps_dec == '0) begin
                phase_d     = PhIdle;
                move_done_o = 1'b1;
              end else begin
                // Plan the delay of the next step.
                unique case (phase_q)
                  PhAccel: begin
                    if (sil_inc >= cfg_i.slope_steps) begin
                      sil_d      = '0;
                      level_sel  = level_q + 6'd1;
                      level_d    = level_sel;
                      load_delay = 1'b1;
                      if (level_sel >= cfg_i.slope_count) phase_d = PhCruise;
                    end else begin
                      sil_d = sil_inc;
                    end
                  end
                  PhCruise: begin
                    if (ramp != '0 && CmpW'(steps_dec) == CmpW'(ramp)) begin
                      phase_d    = PhDecel;
                      level_sel  = cfg_i.slope_count - 6'd1;
                      level_d    = level_sel;
                      sil_d      = '0;
                      load_delay = 1'b1;
                    end
                  end
                  PhDecel: begin
                    if (sil_inc >= cfg_i.slope_steps && level_q != '0) begin
                      sil_d      = '0;
                      level_sel  = level_q - 6'd1;
                      level_d    = level_sel;
                      load_delay = 1'b1;
                    end else begin
                      sil_d = sil_inc;
                    end
                  end
                  default: ;
                endcase
              end
            end else begin
              tick_d = tick_q + {{DelayBits{1'b0}}, 1'b1};
            end
          end
        end
        tspg_pkg::KindStart: begin
          if (phase_q == PhIdle) begin
            rdir_d = move_dir_i;
            cdir_d = cfg_i.direction_sense ? move_dir_i : ~move_dir_i;
            if (move_steps_i != '0) begin
              steps_left_d = StepCountBits'(move_steps_i);
              tick_d       = '0;
              level_d      = '0;
              sil_d        = '0;
              load_delay   = 1'b1;
              if (move_steps_i > {1'b0, ramp, 1'b0}) begin
                if (cfg_i.slope_count == '0 || cfg_i.slope_steps == '0) begin
                  phase_d   = PhCruise;
                  level_sel = cfg_i.slope_count;
                end else begin
                  phase_d = PhAccel;
                end
              end else begin
                // Level zero delay is the plain base delay.
                phase_d = PhFlat;
              end
            end
          end
        end
        tspg_pkg::KindZero: pos_ctrl_o.zero = 1'b1;
        default: ;
      endcase
    end

    if (load_delay) delay_d = lvl_delay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      steps_left_q <= '0;
      delay_q      <= '0;
      level_q      <= '0;
      sil_q        <= '0;
      tick_q       <= '0;
      cdir_q       <= 1'b0;
      rdir_q       <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      steps_left_q <= steps_left_d;
      delay_q      <= delay_d;
      level_q      <= level_d;
      sil_q        <= sil_d;
      tick_q       <= tick_d;
      cdir_q       <= cdir_d;
      rdir_q       <= rdir_d;
    end
  end

  assign busy_o      = (phase_d != PhIdle);
  assign dir_level_o = rdir_d;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  import tspg_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam longint unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandomRequests = 560;
  localparam int unsigned MaxReports = 40;

  typedef enum logic [2:0] {
    MotionIdle,
    MotionFlat,
    MotionAccel,
    MotionCruise,
    MotionDecel
  } motion_phase_t;

  typedef struct packed {
    logic [KindW-1:0]      kind;
    logic [MoveStepsW-1:0] steps;
    logic                  forward;
  } motion_request_t;

  // Same bit order as the result stream, step_pulse in bit 0.
  typedef struct packed {
    logic [RevW-1:0]      revolutions;
    logic [PositionW-1:0] position;
    logic                 move_done;
    logic                 busy;
    logic                 dir_level;
    logic                 step_pulse;
  } motion_status_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  trapezoid_step_pulse_generator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  motion_request_t pending_requests[$];
  motion_status_t  expected_status[$];
  motion_request_t active_request = '0;
  motion_status_t  expected_now;
  motion_status_t  got_now;

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned pulse_count    = 0;
  int unsigned done_count     = 0;
  int unsigned setting_count  = 0;
  int unsigned error_count    = 0;
  longint unsigned cycle_count = 0;
  logic steady_flow = 1'b0;

  // Register copies, starting from the reset values.
  int unsigned cfg_base_delay  = BaseDelayRst;
  int unsigned cfg_slope_steps = SlopeStepsRst;
  int unsigned cfg_slope_count = SlopeCountRst;
  int unsigned cfg_delay_dec   = DelayDecRst;
  int unsigned cfg_dir_sense   = DirSenseRst;
  int unsigned cfg_rev_steps   = RevStepsRst;

  // Motion state of the profile predictor.
  motion_phase_t   motion_phase    = MotionIdle;
  logic [15:0]     steps_remaining = '0;
  int unsigned     wait_ticks      = 0;
  logic [5:0]      speed_level     = '0;
  logic [7:0]      level_step      = '0;
  int unsigned     tick_in_step    = 0;
  logic            count_forward   = 1'b0;
  logic            dir_latched     = 1'b0;
  int              arm_position    = 0;
  int              turn_count      = 0;

  function automatic int unsigned level_delay(int unsigned level);
    int unsigned drop;
    drop = level * cfg_delay_dec;
    return (drop >= cfg_base_delay) ? 0 : cfg_base_delay - drop;
  endfunction

  function automatic void move_arm();
    int  span;
    logic wrap_up;
    logic wrap_down;
    span = (cfg_rev_steps == 0) ? 1 : int'(cfg_rev_steps);
    arm_position += count_forward ? 1 : -1;
    // The wrap window depends on the sign of the revolution count.
    if (turn_count == 0) begin
      wrap_up   = arm_position > span;
      wrap_down = arm_position < -span;
    end else if (turn_count > 0) begin
      wrap_up   = arm_position > span;
      wrap_down = arm_position < 1;
    end else begin
      wrap_down = arm_position < -span;
      wrap_up   = arm_position > -1;
    end
    if (wrap_up) begin
      arm_position -= span;
      if (turn_count < 32767) turn_count++;
    end else if (wrap_down) begin
      arm_position += span;
      if (turn_count > -32768) turn_count--;
    end
  endfunction

  function automatic void plan_next_step();
    int unsigned ramp_steps;
    ramp_steps = cfg_slope_count * cfg_slope_steps;
    case (motion_phase)
      MotionAccel: begin
        level_step++;
        if (level_step >= cfg_slope_steps) begin
          level_step = '0;
          speed_level++;
          if (speed_level >= cfg_slope_count) motion_phase = MotionCruise;
          wait_ticks = level_delay(speed_level);
        end
      end
      MotionCruise: begin
        // Deceleration starts against the live registers.
        if (ramp_steps != 0 && steps_remaining == ramp_steps) begin
          motion_phase = MotionDecel;
          speed_level  = 6'(cfg_slope_count - 1);
          level_step   = '0;
          wait_ticks   = level_delay(speed_level);
        end
      end
      MotionDecel: begin
        level_step++;
        if (level_step >= cfg_slope_steps && speed_level > 0) begin
          level_step = '0;
          speed_level--;
          wait_ticks = level_delay(speed_level);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void begin_move(int unsigned move_len, logic forward);
    dir_latched   = forward;
    count_forward = cfg_dir_sense ? forward : !forward;
    if (move_len == 0) return;
    steps_remaining = 16'(move_len);
    tick_in_step    = 0;
    speed_level     = '0;
    level_step      = '0;
    if (move_len > 2 * cfg_slope_count * cfg_slope_steps) begin
      if (cfg_slope_count == 0 || cfg_slope_steps == 0) begin
        motion_phase = MotionCruise;
        wait_ticks   = level_delay(cfg_slope_count);
      end else begin
        motion_phase = MotionAccel;
        wait_ticks   = level_delay(0);
      end
    end else begin
      motion_phase = MotionFlat;
      wait_ticks   = cfg_base_delay;
    end
  endfunction

  function automatic motion_status_t predict_status(motion_request_t req);
    motion_status_t st;
    st = '0;
    case (req.kind)
      KindTick: begin
        if (motion_phase != MotionIdle) begin
          if (tick_in_step == 0) begin
            st.step_pulse = 1'b1;
            move_arm();
          end
          if (tick_in_step >= 1 + wait_ticks) begin
            tick_in_step = 0;
            steps_remaining--;
            if (steps_remaining == 0) begin
              motion_phase = MotionIdle;
              st.move_done = 1'b1;
            end else begin
              plan_next_step();
            end
          end else begin
            tick_in_step++;
          end
        end
      end
      KindStart: begin
        if (motion_phase == MotionIdle) begin_move(req.steps, req.forward);
      end
      KindZero: begin
        arm_position = 0;
        turn_count   = 0;
      end
      default: ;
    endcase
    st.dir_level   = dir_latched;
    st.busy        = motion_phase != MotionIdle;
    st.position    = arm_position[PositionW-1:0];
    st.revolutions = turn_count[RevW-1:0];
    return st;
  endfunction

  function automatic void queue_request(logic [KindW-1:0] kind, logic [MoveStepsW-1:0] steps,
                                        logic forward);
    motion_request_t req;
    req.kind    = kind;
    req.steps   = steps;
    req.forward = forward;
    pending_requests.push_back(req);
    queued_count++;
  endfunction

  function automatic void check_field(string field_name, int exp_value, int got_value);
    if (exp_value != got_value) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, exp_value,
                 got_value);
    end
  endfunction

  task automatic write_register(logic [CfgIdxW-1:0] index, int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value[CfgDataW-1:0];
    case (index)
      RegBaseDelay:  cfg_base_delay  = value & 16'hFFFF;
      RegSlopeSteps: cfg_slope_steps = value & 8'hFF;
      RegSlopeCount: cfg_slope_count = value & 6'h3F;
      RegDelayDec:   cfg_delay_dec   = value & 8'hFF;
      RegDirSense:   cfg_dir_sense   = value & 1;
      RegRevSteps:   cfg_rev_steps   = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  // Every request yields one result, so an empty expectation queue with all
  // requests taken means the pipeline is empty.
  task automatic wait_until_drained();
    @(posedge clk_i);
    while (accepted_count != queued_count || expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status.push_back(predict_status(active_request));
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 32)) begin
          active_request = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(InDataW - MoveStepsW - 1){1'b0}}, active_request.forward,
                            active_request.steps};
          s_axis_tuser  <= active_request.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: result with no request outstanding, expected none, actual %h",
                     $time, m_axis_tdata);
        end else begin
          expected_now = expected_status.pop_front();
          got_now      = m_axis_tdata[$bits(motion_status_t)-1:0];
          check_field("step_pulse", expected_now.step_pulse, got_now.step_pulse);
          check_field("dir_level", expected_now.dir_level, got_now.dir_level);
          check_field("busy_res", expected_now.busy, got_now.busy);
          check_field("move_done", expected_now.move_done, got_now.move_done);
          check_field("position", $signed(expected_now.position), $signed(got_now.position));
          check_field("revolutions", $signed(expected_now.revolutions),
                      $signed(got_now.revolutions));
          checked_count++;
          pulse_count += got_now.step_pulse;
          done_count  += got_now.move_done;
        end
      end
      m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned random_total;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned move_len;
    int unsigned burst;
    int unsigned base_now;
    random_total = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Commands at the reset settings: an idle tick, the unused kind and
    // zero-step starts that only latch the direction.
    queue_request(KindTick, '0, 1'b0);
    queue_request(KindUnused, 16'hFFFF, 1'b1);
    queue_request(KindStart, '0, 1'b0);
    queue_request(KindStart, '0, 1'b1);
    wait_until_drained();

    // Short trapezoid counted backward through an inverted direction sense,
    // with a start while busy and a position clear in the middle.
    write_register(RegBaseDelay, 1);
    write_register(RegSlopeSteps, 1);
    write_register(RegSlopeCount, 2);
    write_register(RegDelayDec, 1);
    write_register(RegDirSense, 0);
    write_register(RegRevSteps, 2);
    close_writes();
    queue_request(KindStart, 16'd5, 1'b1);
    queue_request(KindStart, 16'd7, 1'b0);
    repeat (4) queue_request(KindTick, '0, 1'b0);
    queue_request(KindZero, '0, 1'b0);
    repeat (9) queue_request(KindTick, '0, 1'b0);
    wait_until_drained();

    // Empty ramp and a revolution length of zero.
    write_register(RegSlopeSteps, 0);
    write_register(RegSlopeCount, 3);
    write_register(RegBaseDelay, 2);
    write_register(RegDirSense, 1);
    write_register(RegRevSteps, 0);
    close_writes();
    queue_request(KindStart, 16'd3, 1'b0);
    repeat (7) queue_request(KindTick, '0, 1'b0);
    wait_until_drained();

    // Full trapezoids forward and back at full rate, with the cruise delay
    // floored at zero and a short revolution length.
    steady_flow = 1'b1;
    write_register(RegBaseDelay, 3);
    write_register(RegSlopeSteps, 2);
    write_register(RegSlopeCount, 2);
    write_register(RegDelayDec, 2);
    write_register(RegRevSteps, 3);
    close_writes();
    queue_request(KindStart, 16'd12, 1'b1);
    repeat (44) queue_request(KindTick, '0, 1'b0);
    queue_request(KindStart, 16'd12, 1'b0);
    repeat (44) queue_request(KindTick, '0, 1'b0);
    wait_until_drained();
    steady_flow = 1'b0;

    // Random settings with small delays and ramps; registers may change while
    // a move is still running from the previous setting.
    while (random_total < RandomRequests) begin
      base_now = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      write_register(RegBaseDelay, base_now);
      write_register(RegSlopeSteps, $urandom_range(1, 3));
      write_register(RegSlopeCount, $urandom_range(0, 3));
      write_register(RegDelayDec, $urandom_range(0, 3));
      write_register(RegDirSense, $urandom_range(0, 1));
      write_register(RegRevSteps, ($urandom_range(0, 5) == 0) ? 16'hFFFF : $urandom_range(1, 6));
      close_writes();
      phase_start = queued_count;
      while (queued_count - phase_start < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          move_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
          queue_request(KindStart, 16'(move_len), 1'($urandom_range(0, 1)));
          burst = move_len * (base_now + 2) + 1;
          if ($urandom_range(0, 99) >= 65) burst = $urandom_range(0, burst);
          for (int i = 0; i < burst; i++) begin
            queue_request(KindTick, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            if (i < 2 * move_len && $urandom_range(0, 99) < 5) begin
              if ($urandom_range(0, 1))
                queue_request(KindStart, 16'($urandom_range(1, 24)), 1'($urandom_range(0, 1)));
              else
                queue_request(KindZero, 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) < 2)
              queue_request(KindUnused, 16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)));
          end
        end else if (pick < 85) begin
          queue_request(KindTick, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
          queue_request(KindZero, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end else begin
          queue_request(KindUnused, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
      end
      random_total += queued_count - phase_start;
      wait_until_drained();
    end

    $display("Ran %0d requests over %0d register settings: flat, trapezoid and ramp-less moves,",
             accepted_count, setting_count);
    $display("position wrap over short and empty revolutions; %0d step pulses, %0d moves done.",
             pulse_count, done_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
